>>> src/mlr_pkg.sv
package mlr_pkg;

  // field and register widths
  localparam int CNT_W       = 7;
  localparam int COORD_W     = 6;
  localparam int VAL_W       = 32;
  localparam int ROT_W       = 31;
  localparam int RING_W      = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 31;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  // ring length of layer k is 2*(rows+cols) - RING_BIAS - LAYER_STEP*k
  localparam int RING_BIAS  = 4;
  localparam int LAYER_STEP = 8;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 2'd0,
    CFG_COL_COUNT = 2'd1,
    CFG_ROTATION  = 2'd2
  } cfg_idx_t;

endpackage

>>> src/matrix_layer_rotation.sv
// channel | dir | payload
// s_*     | in  | s_tdata: req_type, row, col, value
// m_*     | out | m_tdata: rotated_value, outside (queries only)
// cfg_*   | in  | cfg_index selects row_count, col_count, rotation_count
//
// one item per cycle once ready; five register stages in order
// (layer, ring position, rotated index, source address, store read),
// the store read stage being the output register
// every configuration write starts a bit-serial rebuild of the
// per-layer rotation residues; s_tready stays low meanwhile
// rst is synchronous; store contents are undefined until loaded
// when the output register is full and m_tready is low the whole pipe holds
module matrix_layer_rotation #(
  parameter int MAX_SIDE   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [0] req_type, [6:1] row, [12:7] col, [44:13] value
  input  logic [mlr_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [31:0] rotated_value, [32] outside
  output logic [mlr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                               cfg_we,
  input  logic [mlr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mlr_pkg::*;

  localparam int SIDE_CAP_I = (MAX_SIDE < 127) ? MAX_SIDE : 127;
  localparam logic [CNT_W-1:0] SIDE_CAP = CNT_W'(SIDE_CAP_I);
  localparam int NL    = SIDE_CAP_I / 2;
  localparam int LIW   = (NL > 1) ? $clog2(NL) : 1;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    req_t             req;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             outside;
    logic             in_layer;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  i0;
    logic [CNT_W-1:0]  i1;
    logic [CNT_W-1:0]  j0;
    logic [CNT_W-1:0]  j1;
    logic [CNT_W-1:0]  w;
    logic [CNT_W-1:0]  h;
    logic [RING_W-1:0] p;
  } geo_t;

  typedef struct packed {
    item_t            item;
    logic [CNT_W-1:0] layer;
  } s1_t;

  typedef struct packed {
    item_t             item;
    geo_t              geo;
    logic [RING_W-1:0] pos;
    logic [RING_W-1:0] rmod;
  } s2_t;

  typedef struct packed {
    item_t             item;
    geo_t              geo;
    logic [RING_W-1:0] idx;
  } s3_t;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic                  outside;
    logic [AW-1:0]         addr;
    logic [DATA_WIDTH-1:0] wdata;
  } s4_t;

  // configuration
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;
  logic [ROT_W-1:0] rotation_count;
  logic [CNT_W-1:0] side_m;
  logic [CNT_W-1:0] side_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= CNT_W'(2);
      col_count      <= CNT_W'(2);
      rotation_count <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROW_COUNT: row_count      <= cfg_data[CNT_W-1:0];
        CFG_COL_COUNT: col_count      <= cfg_data[CNT_W-1:0];
        CFG_ROTATION:  rotation_count <= cfg_data[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  assign side_m = (row_count > SIDE_CAP) ? SIDE_CAP : row_count;
  assign side_n = (col_count > SIDE_CAP) ? SIDE_CAP : col_count;

  // pipeline control
  logic adv;
  logic busy;
  logic v1, v2, v3, v4, out_valid;
  s1_t  s1;
  s2_t  s2;
  s3_t  s3;
  s4_t  s4;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  out_outside;
  logic [RING_W-1:0]     rmod;

  assign adv      = !out_valid || m_tready;
  assign s_tready = adv && !busy;

  mlr_residue #(
    .LIW (LIW)
  ) u_residue (
    .clk       (clk),
    .rst       (rst),
    .start     (cfg_we),
    .side_rows (side_m),
    .side_cols (side_n),
    .rotation  (rotation_count),
    .layer     (s1.layer[LIW-1:0]),
    .busy      (busy),
    .residue   (rmod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= s_tvalid && s_tready;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4 && s4.re | (v4 && s4.outside);
    end
  end

  // stage a: bounds and layer
  logic [CNT_W-1:0] a_row, a_col, a_rb, a_cr, a_min1, a_min2, a_layer, a_half;
  item_t            a_item;

  always_comb begin
    a_row   = CNT_W'(s_tdata[6:1]);
    a_col   = CNT_W'(s_tdata[12:7]);
    a_rb    = side_m - 1'b1 - a_row;
    a_cr    = side_n - 1'b1 - a_col;
    a_min1  = (a_row < a_col) ? a_row : a_col;
    a_min2  = (a_rb < a_cr) ? a_rb : a_cr;
    a_layer = (a_min1 < a_min2) ? a_min1 : a_min2;
    a_half  = ((side_m >> 1) < (side_n >> 1)) ? (side_m >> 1) : (side_n >> 1);
    a_item.req      = req_t'(s_tdata[0]);
    a_item.row      = a_row;
    a_item.col      = a_col;
    a_item.value    = s_tdata[44:13];
    a_item.outside  = (a_row >= side_m) || (a_col >= side_n);
    a_item.in_layer = a_layer < a_half;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.item  <= a_item;
      s1.layer <= a_layer;
    end
  end

  // stage b: ring geometry and position along the ring
  geo_t              b_geo;
  logic [RING_W-1:0] b_pos;

  always_comb begin
    b_geo.i0 = s1.layer;
    b_geo.j0 = s1.layer;
    b_geo.i1 = side_m - 1'b1 - s1.layer;
    b_geo.j1 = side_n - 1'b1 - s1.layer;
    b_geo.h  = b_geo.i1 - b_geo.i0;
    b_geo.w  = b_geo.j1 - b_geo.j0;
    b_geo.p  = (RING_W'(b_geo.h) + RING_W'(b_geo.w)) << 1;
    if (s1.item.row == b_geo.i0 && s1.item.col < b_geo.j1) begin
      b_pos = RING_W'(s1.item.col - b_geo.j0);
    end else if (s1.item.col == b_geo.j1 && s1.item.row < b_geo.i1) begin
      b_pos = RING_W'(b_geo.w) + RING_W'(s1.item.row - b_geo.i0);
    end else if (s1.item.row == b_geo.i1 && s1.item.col > b_geo.j0) begin
      b_pos = RING_W'(b_geo.w) + RING_W'(b_geo.h) + RING_W'(b_geo.j1 - s1.item.col);
    end else begin
      b_pos = (RING_W'(b_geo.w) << 1) + RING_W'(b_geo.h)
              + RING_W'(b_geo.i1 - s1.item.row);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.item <= s1.item;
      s2.geo  <= b_geo;
      s2.pos  <= b_pos;
      s2.rmod <= rmod;
    end
  end

  // stage c: source index along the ring
  logic [RING_W:0]   c_sum;
  logic [RING_W-1:0] c_idx;

  always_comb begin
    c_sum = (RING_W+1)'(s2.pos) + (RING_W+1)'(s2.rmod);
    if (c_sum >= {1'b0, s2.geo.p}) begin
      c_idx = RING_W'(c_sum - {1'b0, s2.geo.p});
    end else begin
      c_idx = RING_W'(c_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3.item <= s2.item;
      s3.geo  <= s2.geo;
      s3.idx  <= c_idx;
    end
  end

  // stage d: source coordinates and store address
  logic [RING_W-1:0] d_w, d_wh, d_wwh;
  logic [CNT_W-1:0]  d_sr, d_sc;
  logic              d_load_ok;
  s4_t               d_op;

  always_comb begin
    d_w   = RING_W'(s3.geo.w);
    d_wh  = d_w + RING_W'(s3.geo.h);
    d_wwh = d_wh + d_w;
    d_sr  = s3.item.row;
    d_sc  = s3.item.col;
    // loads write where they point, if that lies inside the store
    if (s3.item.in_layer && s3.item.req == REQ_QUERY) begin
      if (s3.idx < d_w) begin
        d_sr = s3.geo.i0;
        d_sc = s3.geo.j0 + CNT_W'(s3.idx);
      end else if (s3.idx < d_wh) begin
        d_sr = s3.geo.i0 + CNT_W'(s3.idx - d_w);
        d_sc = s3.geo.j1;
      end else if (s3.idx < d_wwh) begin
        d_sr = s3.geo.i1;
        d_sc = s3.geo.j1 - CNT_W'(s3.idx - d_wh);
      end else begin
        d_sr = s3.geo.i1 - CNT_W'(s3.idx - d_wwh);
        d_sc = s3.geo.j0;
      end
    end
    d_load_ok    = (int'(s3.item.row) < MAX_SIDE) && (int'(s3.item.col) < MAX_SIDE);
    d_op.we      = (s3.item.req == REQ_LOAD) && d_load_ok;
    d_op.re      = (s3.item.req == REQ_QUERY) && !s3.item.outside;
    d_op.outside = (s3.item.req == REQ_QUERY) && s3.item.outside;
    d_op.addr    = AW'(int'(d_sr) * MAX_SIDE + int'(d_sc));
    d_op.wdata   = DATA_WIDTH'(signed'(s3.item.value));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4 <= d_op;
    end
  end

  // stage e: element store, read data doubles as the output register
  logic [DATA_WIDTH-1:0] grid_store [DEPTH];

  always_ff @(posedge clk) begin
    if (adv && v4 && s4.we) begin
      grid_store[s4.addr] <= s4.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v4 && s4.re) begin
      rdata <= grid_store[s4.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_outside <= s4.outside;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_TDATA_W - VAL_W - 1)'(0), out_outside,
                     out_outside ? VAL_W'(0) : VAL_W'(rdata)};

  // checks
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready)
    else $error("input taken during residue rebuild");

  a_cfg_starts_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("configuration write did not hold off input");

  a_pos_on_ring: assert property (@(posedge clk) disable iff (rst)
    (v2 && s2.item.req == REQ_QUERY && !s2.item.outside && s2.item.in_layer)
      |-> (s2.pos < s2.geo.p) && (s2.rmod < s2.geo.p))
    else $error("ring position or residue beyond ring length");

  a_idx_on_ring: assert property (@(posedge clk) disable iff (rst)
    (v3 && s3.item.req == REQ_QUERY && !s3.item.outside && s3.item.in_layer)
      |-> (s3.idx < s3.geo.p))
    else $error("rotated index beyond ring length");

endmodule

>>> src/mlr_residue.sv
module mlr_residue #(
  parameter int LIW = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mlr_pkg::CNT_W-1:0]   side_rows,
  input  logic [mlr_pkg::CNT_W-1:0]   side_cols,
  input  logic [mlr_pkg::ROT_W-1:0]   rotation,
  input  logic [LIW-1:0]              layer,
  output logic                        busy,
  output logic [mlr_pkg::RING_W-1:0]  residue
);
  import mlr_pkg::*;

  localparam int LANES = 2 ** LIW;
  localparam int BIT_W = $clog2(ROT_W);

  logic [RING_W-1:0] res       [LANES];
  logic [RING_W-1:0] lane_len  [LANES];
  logic [RING_W-1:0] lane_next [LANES];
  logic [RING_W:0]   lane_shift [LANES];
  logic [RING_W:0]   ring0;
  logic [BIT_W-1:0]  bit_sel;

  assign ring0 = (((RING_W+1)'(side_rows) + (RING_W+1)'(side_cols)) << 1)
                 - (RING_W+1)'(RING_BIAS);

  // one lane per layer: shift in the next bit of the rotation, fold back once
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_len[k]   = RING_W'(ring0 - (RING_W+1)'(LAYER_STEP * k));
      lane_shift[k] = {res[k], rotation[bit_sel]};
      if (lane_shift[k] >= {1'b0, lane_len[k]}) begin
        lane_next[k] = RING_W'(lane_shift[k] - {1'b0, lane_len[k]});
      end else begin
        lane_next[k] = RING_W'(lane_shift[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_sel <= '0;
      for (int k = 0; k < LANES; k++) res[k] <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      bit_sel <= BIT_W'(ROT_W - 1);
      for (int k = 0; k < LANES; k++) res[k] <= '0;
    end else if (busy) begin
      for (int k = 0; k < LANES; k++) res[k] <= lane_next[k];
      if (bit_sel == '0) begin
        busy <= 1'b0;
      end else begin
        bit_sel <= bit_sel - 1'b1;
      end
    end
  end

  assign residue = res[layer];

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mlr_pkg::*;

  localparam int SIDE         = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD    = 400;

  typedef struct {
    logic [VAL_W-1:0] value;
    bit               outside;
  } cell_result_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // shadow of the block: layout registers and matrix contents
  int               rows_used;
  int               cols_used;
  longint           turn_steps;
  logic [VAL_W-1:0] grid_mem [SIDE*SIDE];
  bit               written [SIDE*SIDE];

  cell_result_t expected_cells[$];
  int           error_count;
  bit           idle_gaps;
  int           hold_request;
  int           cycles;

  matrix_layer_rotation DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int min2(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic bit is_outside(input int r, input int c);
    return (r >= min2(rows_used, SIDE)) || (c >= min2(cols_used, SIDE));
  endfunction

  // where the element shown at (r, c) after rotation comes from
  function automatic void ring_source(input int r, input int c, output int sr, output int sc);
    int m, n, l, i1, j1, h, w, p, pos, idx;
    m = min2(rows_used, SIDE);
    n = min2(cols_used, SIDE);
    sr = r;
    sc = c;
    l = min2(min2(r, c), min2(m - 1 - r, n - 1 - c));
    // centre cells of odd layouts belong to no full ring
    if (l < min2(m / 2, n / 2)) begin
      i1 = m - 1 - l;
      j1 = n - 1 - l;
      h = i1 - l;
      w = j1 - l;
      p = 2 * (h + w);
      // position along the ring, clockwise from the top-left corner
      if (r == l && c < j1) pos = c - l;
      else if (c == j1 && r < i1) pos = w + r - l;
      else if (r == i1 && c > l) pos = w + h + j1 - c;
      else pos = 2 * w + h + i1 - r;
      idx = int'((longint'(pos) + turn_steps % p) % p);
      if (idx < w) begin
        sr = l;
        sc = l + idx;
      end else if (idx < w + h) begin
        sr = l + idx - w;
        sc = j1;
      end else if (idx < 2 * w + h) begin
        sr = i1;
        sc = j1 - (idx - w - h);
      end else begin
        sr = i1 - (idx - 2 * w - h);
        sc = l;
      end
    end
  endfunction

  function automatic logic [VAL_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic int draw_gap();
    return idle_gaps ? $urandom_range(0, 10) : 0;
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("%0t mismatch on %s: got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  // one transfer on the input side; valid stays high for a back-to-back item
  task automatic send_item(input req_t kind, input int r, input int c,
                           input logic [VAL_W-1:0] v);
    int gap;
    int sr, sc;
    cell_result_t res;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, v, 6'(c), 6'(r), kind};
    do @(posedge clk); while (!s_tready);
    if (kind == REQ_LOAD) begin
      grid_mem[r * SIDE + c] = v;
      written[r * SIDE + c]  = 1'b1;
    end else begin
      if (is_outside(r, c)) begin
        res.value   = '0;
        res.outside = 1'b1;
      end else begin
        ring_source(r, c, sr, sc);
        res.value   = grid_mem[sr * SIDE + sc];
        res.outside = 1'b0;
      end
      expected_cells.push_back(res);
    end
  endtask

  // loads the source cell first when it has never been written
  task automatic query_cell(input int r, input int c);
    int sr, sc;
    if (!is_outside(r, c)) begin
      ring_source(r, c, sr, sc);
      if (!written[sr * SIDE + sc]) send_item(REQ_LOAD, sr, sc, random_word());
    end
    send_item(REQ_QUERY, r, c, $urandom());
  endtask

  task automatic query_random();
    int m, n;
    m = min2(rows_used, SIDE);
    n = min2(cols_used, SIDE);
    if (m > 0 && n > 0 && $urandom_range(0, 9) != 0)
      query_cell($urandom_range(0, m - 1), $urandom_range(0, n - 1));
    else
      query_cell($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1));
  endtask

  // drop valid, let every result arrive and the last loads retire
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_layout(input int rows, input int cols, input logic [ROT_W-1:0] steps);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= CFG_DATA_W'(rows);
    @(posedge clk);
    rows_used = rows;
    cfg_index <= CFG_COL_COUNT;
    cfg_data  <= CFG_DATA_W'(cols);
    @(posedge clk);
    cols_used = cols;
    cfg_index <= CFG_ROTATION;
    cfg_data  <= steps;
    @(posedge clk);
    turn_steps = steps;
    cfg_we <= 1'b0;
  endtask

  task automatic test_small_grid();
    // reset layout is 2x2 with no rotation
    send_item(REQ_LOAD, 0, 0, 32'h7fff_ffff);
    send_item(REQ_LOAD, 0, 1, 32'h8000_0000);
    send_item(REQ_LOAD, 1, 0, 32'h0000_0000);
    send_item(REQ_LOAD, 1, 1, 32'hffff_ffff);
    for (int i = 0; i < 4; i++) query_cell(i / 2, i % 2);
    query_cell(0, 2);
    query_cell(2, 0);
    query_cell(63, 63);
    set_layout(2, 2, 31'h7fff_ffff);
    for (int i = 0; i < 4; i++) query_cell(i / 2, i % 2);
  endtask

  task automatic test_size_edges();
    set_layout(0, 5, 7);
    query_cell(0, 0);
    // a single row has no full ring; column count saturates
    set_layout(1, 127, 5);
    query_cell(0, 63);
    query_cell(0, 7);
    set_layout(5, 3, 1);
    query_cell(1, 1);
    query_cell(2, 1);
    query_cell(4, 2);
    set_layout(127, 127, 31'h7fff_ffff);
    query_cell(63, 63);
    query_cell(31, 32);
    query_cell(63, 0);
  endtask

  task automatic test_random_layouts(input int phases, input int items);
    int rows, cols;
    logic [ROT_W-1:0] steps;
    for (int ph = 0; ph < phases; ph++) begin
      case ($urandom_range(0, 9))
        0: begin
          rows = $urandom_range(0, 127);
          cols = $urandom_range(0, 127);
        end
        1, 2: begin
          rows = 2 * $urandom_range(0, 31) + 1;
          cols = $urandom_range(1, 64);
        end
        default: begin
          rows = 2 * $urandom_range(1, 32);
          cols = 2 * $urandom_range(1, 32);
        end
      endcase
      case ($urandom_range(0, 5))
        0: steps = '0;
        1: steps = '1;
        2, 3: steps = ROT_W'($urandom());
        default: steps = ROT_W'($urandom_range(0, 500));
      endcase
      set_layout(rows, cols, steps);
      idle_gaps = ($urandom_range(0, 3) != 0);
      repeat (items) begin
        if ($urandom_range(0, 9) < 7) query_random();
        else send_item(REQ_LOAD, $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                       random_word());
      end
    end
    idle_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    set_layout(64, 64, ROT_W'($urandom()));
    idle_gaps    = 1'b0;
    hold_request = LONG_HOLD;
    repeat (80) query_random();
    settle();
    idle_gaps = 1'b1;
  endtask

  task automatic test_drain_pause();
    set_layout(2 * $urandom_range(1, 32), 2 * $urandom_range(1, 32),
               ROT_W'($urandom_range(0, 5000)));
    repeat (40) query_random();
    // sender waits for every outstanding result before carrying on
    settle();
    repeat (40) query_random();
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("unexpected transfer", m_tdata[31:0], '0);
      end else begin
        want = expected_cells.pop_front();
        if (m_tdata[31:0] !== want.value)
          report_mismatch("rotated_value", m_tdata[31:0], want.value);
        if (m_tdata[32] !== want.outside)
          report_mismatch("outside", VAL_W'(m_tdata[32]), VAL_W'(want.outside));
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_ROW_COUNT;
    cfg_data     = '0;
    rows_used    = 2;
    cols_used    = 2;
    turn_steps   = 0;
    error_count  = 0;
    idle_gaps    = 1'b1;
    hold_request = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_grid();
    test_size_edges();
    test_backpressure();
    test_random_layouts(16, 50);
    test_drain_pause();
    settle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
src/mlr_pkg.sv
src/mlr_residue.sv
src/matrix_layer_rotation.sv
tb/sv/tb_top.sv
